// ===== sv/swss_pkg.sv =====
`timescale 1ns / 1ps

package swss_pkg;

    localparam int STACK_DEPTH  = 1024;
    localparam int MAX_CHUNK    = 16;
    localparam int HANDLE_WIDTH = 64;

    // Field widths fixed by the interface.
    localparam int KIND_W   = 3;
    localparam int TASK_W   = 64;
    localparam int HEIGHT_W = 16;
    localparam int AMT_W    = 5;
    localparam int IDX_W    = 11;
    localparam int COUNT_W  = 32;
    localparam int ERR_W    = 2;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(MAX_CHUNK + 1);

    localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACQUIRE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STEAL   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd5;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY    = 2'd2;
    localparam logic [ERR_W-1:0] ERR_RELEASE  = 2'd3;

    typedef struct packed {
        logic [TASK_W-1:0]   task_out;
        logic                success;
        logic [ERR_W-1:0]    error_code;
        logic [IDX_W-1:0]    local_depth;
        logic [IDX_W-1:0]    shared_available;
        logic [IDX_W-1:0]    top_position;
        logic [COUNT_W-1:0]  pushed_total;
        logic [IDX_W-1:0]    peak_depth;
        logic [HEIGHT_W-1:0] peak_height;
        logic                last;
    } res_t;

endpackage

// ===== sv/swss_ram.sv =====
`timescale 1ns / 1ps

module swss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/swss_core.sv =====
`timescale 1ns / 1ps

module swss_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [swss_pkg::KIND_W-1:0]   kind,
    input  logic [swss_pkg::TASK_W-1:0]   task_handle,
    input  logic [swss_pkg::HEIGHT_W-1:0] task_height,
    input  logic [swss_pkg::AMT_W-1:0]    amount,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [swss_pkg::IDX_W-1:0]    cfg_data,
    output logic                          res_valid,
    input  logic                          res_ready,
    output swss_pkg::res_t                res
);

    import swss_pkg::*;

    typedef enum logic [0:0] {
        S_IDLE,
        S_SEND
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     top_reg, top_next;
    logic [IDX_W-1:0]     lb_reg, lb_next;
    logic [IDX_W-1:0]     ss_reg, ss_next;
    logic [COUNT_W-1:0]   push_cnt_reg, push_cnt_next;
    logic [IDX_W-1:0]     maxd_reg, maxd_next;
    logic [HEIGHT_W-1:0]  maxh_reg, maxh_next;
    logic [IDX_W-1:0]     cap_reg, cap_next;
    logic                 ok_reg, ok_next;
    logic [ERR_W-1:0]     err_reg, err_next;
    logic                 mem_reg, mem_next;
    logic                 run_reg, run_next;
    logic [IDX_W-1:0]     base_reg, base_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     amt_reg, amt_next;

    logic [IDX_W-1:0]        cap_eff;
    logic [IDX_W-1:0]        amt_ext;
    logic [IDX_W-1:0]        local_cnt;
    logic [IDX_W-1:0]        shared_cnt;
    logic [IDX_W-1:0]        rd_idx;
    logic                    last_beat;
    logic                    mem_we;
    logic                    mem_re;
    logic [HANDLE_WIDTH-1:0] mem_rdata;

    swss_ram #(
        .WIDTH (HANDLE_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (top_reg[ADDR_W-1:0]),
        .wdata (task_handle[HANDLE_WIDTH-1:0]),
        .re    (mem_re),
        .raddr (rd_idx[ADDR_W-1:0]),
        .rdata (mem_rdata)
    );

    assign cap_eff    = (cap_reg > IDX_W'(STACK_DEPTH)) ? IDX_W'(STACK_DEPTH) : cap_reg;
    assign amt_ext    = IDX_W'(amount);
    assign local_cnt  = top_reg - lb_reg;
    assign shared_cnt = lb_reg - ss_reg;
    assign last_beat  = !run_reg || ((cnt_reg + CNT_W'(1)) == amt_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign res_valid = (state_reg == S_SEND);

    // Index fields already carry the state after the step; the task comes
    // straight from the memory read register, which holds while stalled.
    always_comb
    begin
        res.task_out         = mem_reg ? TASK_W'(mem_rdata) : '0;
        res.success          = ok_reg;
        res.error_code       = err_reg;
        res.local_depth      = local_cnt;
        res.shared_available = shared_cnt;
        res.top_position     = top_reg;
        res.pushed_total     = push_cnt_reg;
        res.peak_depth       = maxd_reg;
        res.peak_height      = maxh_reg;
        res.last             = last_beat;
    end

    always_comb
    begin
        state_next    = state_reg;
        top_next      = top_reg;
        lb_next       = lb_reg;
        ss_next       = ss_reg;
        push_cnt_next = push_cnt_reg;
        maxd_next     = maxd_reg;
        maxh_next     = maxh_reg;
        cap_next      = cfg_valid ? cfg_data : cap_reg;
        ok_next       = ok_reg;
        err_next      = err_reg;
        mem_next      = mem_reg;
        run_next      = run_reg;
        base_next     = base_reg;
        cnt_next      = cnt_reg;
        amt_next      = amt_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        rd_idx        = base_reg + IDX_W'(cnt_reg) + IDX_W'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SEND;
                    ok_next    = 1'b0;
                    err_next   = ERR_NONE;
                    mem_next   = 1'b0;
                    run_next   = 1'b0;
                    cnt_next   = '0;
                    case (kind)
                        KIND_PUSH:
                        begin
                            if (top_reg < cap_eff)
                            begin
                                mem_we        = 1'b1;
                                top_next      = top_reg + IDX_W'(1);
                                push_cnt_next = push_cnt_reg + COUNT_W'(1);
                                if ((top_reg + IDX_W'(1)) > maxd_reg)
                                begin
                                    maxd_next = top_reg + IDX_W'(1);
                                end
                                if (task_height > maxh_reg)
                                begin
                                    maxh_next = task_height;
                                end
                                ok_next = 1'b1;
                            end
                            else
                            begin
                                err_next = ERR_OVERFLOW;
                            end
                        end
                        KIND_POP:
                        begin
                            if (top_reg > lb_reg)
                            begin
                                top_next = top_reg - IDX_W'(1);
                                rd_idx   = top_reg - IDX_W'(1);
                                mem_re   = 1'b1;
                                mem_next = 1'b1;
                                ok_next  = 1'b1;
                            end
                            else
                            begin
                                err_next = ERR_EMPTY;
                            end
                        end
                        KIND_RELEASE:
                        begin
                            if (local_cnt >= amt_ext)
                            begin
                                lb_next = lb_reg + amt_ext;
                                ok_next = 1'b1;
                            end
                            else
                            begin
                                err_next = ERR_RELEASE;
                            end
                        end
                        KIND_ACQUIRE:
                        begin
                            if (shared_cnt >= amt_ext)
                            begin
                                lb_next = lb_reg - amt_ext;
                                ok_next = 1'b1;
                            end
                        end
                        KIND_STEAL:
                        begin
                            if (int'(amount) <= MAX_CHUNK && shared_cnt >= amt_ext)
                            begin
                                ss_next = ss_reg + amt_ext;
                                ok_next = 1'b1;
                                if (amount != '0)
                                begin
                                    // The first entry of the run is read now, the
                                    // rest one per delivered beat.
                                    rd_idx    = ss_reg;
                                    mem_re    = 1'b1;
                                    mem_next  = 1'b1;
                                    run_next  = 1'b1;
                                    base_next = ss_reg;
                                    amt_next  = CNT_W'(amount);
                                end
                            end
                        end
                        KIND_EMPTY:
                        begin
                            top_next  = '0;
                            lb_next   = '0;
                            ss_next   = '0;
                            maxd_next = '0;
                            ok_next   = 1'b1;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            S_SEND:
            begin
                if (res_ready)
                begin
                    if (!last_beat)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        mem_re   = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            top_reg      <= '0;
            lb_reg       <= '0;
            ss_reg       <= '0;
            push_cnt_reg <= '0;
            maxd_reg     <= '0;
            maxh_reg     <= '0;
            cap_reg      <= IDX_W'(STACK_DEPTH);
            ok_reg       <= 1'b0;
            err_reg      <= ERR_NONE;
            mem_reg      <= 1'b0;
            run_reg      <= 1'b0;
            base_reg     <= '0;
            cnt_reg      <= '0;
            amt_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            top_reg      <= top_next;
            lb_reg       <= lb_next;
            ss_reg       <= ss_next;
            push_cnt_reg <= push_cnt_next;
            maxd_reg     <= maxd_next;
            maxh_reg     <= maxh_next;
            cap_reg      <= cap_next;
            ok_reg       <= ok_next;
            err_reg      <= err_next;
            mem_reg      <= mem_next;
            run_reg      <= run_next;
            base_reg     <= base_next;
            cnt_reg      <= cnt_next;
            amt_reg      <= amt_next;
        end
    end

endmodule

// ===== sv/swss_obuf.sv =====
`timescale 1ns / 1ps

module swss_obuf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           res_valid,
    output logic           res_ready,
    input  swss_pkg::res_t res,
    output logic           out_valid,
    input  logic           out_ready,
    output swss_pkg::res_t out_res
);

    import swss_pkg::*;

    logic valid_reg;
    res_t data_reg;

    // A held beat moves out in the same cycle that a new one is loaded.
    assign res_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            data_reg <= res;
        end
    end

endmodule

// ===== sv/split_work_stealing_stack_unit.sv =====
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// in        in_valid / in_ready     kind, task_handle, task_height, amount
// out       out_valid / out_ready   task_out, success, error_code, local_depth,
//                                   shared_available, top_position, pushed_total,
//                                   peak_depth, peak_height, last
// cfg       cfg_valid / cfg_ready   cfg_data (capacity)
//
// Each item is decoded and touches the task memory in S_IDLE; its result beat
// is then handed to the output register from S_SEND. A steal of k tasks makes
// one memory read per stolen task, streamed back to back unless the output stalls.
// After reset all indices and counters are zero and capacity is 1024; the task
// memory is not cleared. A stalled output holds one beat while the core holds
// the next; input is taken again once the last beat of an item has left the core.

module split_work_stealing_stack_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [swss_pkg::KIND_W-1:0]   kind,
    input  logic [swss_pkg::TASK_W-1:0]   task_handle,
    input  logic [swss_pkg::HEIGHT_W-1:0] task_height,
    input  logic [swss_pkg::AMT_W-1:0]    amount,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [swss_pkg::IDX_W-1:0]    cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [swss_pkg::TASK_W-1:0]   task_out,
    output logic                          success,
    output logic [swss_pkg::ERR_W-1:0]    error_code,
    output logic [swss_pkg::IDX_W-1:0]    local_depth,
    output logic [swss_pkg::IDX_W-1:0]    shared_available,
    output logic [swss_pkg::IDX_W-1:0]    top_position,
    output logic [swss_pkg::COUNT_W-1:0]  pushed_total,
    output logic [swss_pkg::IDX_W-1:0]    peak_depth,
    output logic [swss_pkg::HEIGHT_W-1:0] peak_height,
    output logic                          last
);

    import swss_pkg::*;

    logic core_valid;
    logic core_ready;
    res_t core_res;
    res_t out_res;

    swss_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .task_handle (task_handle),
        .task_height (task_height),
        .amount      (amount),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .res_valid   (core_valid),
        .res_ready   (core_ready),
        .res         (core_res)
    );

    swss_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (core_valid),
        .res_ready (core_ready),
        .res       (core_res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign task_out         = out_res.task_out;
    assign success          = out_res.success;
    assign error_code       = out_res.error_code;
    assign local_depth      = out_res.local_depth;
    assign shared_available = out_res.shared_available;
    assign top_position     = out_res.top_position;
    assign pushed_total     = out_res.pushed_total;
    assign peak_depth       = out_res.peak_depth;
    assign peak_height      = out_res.peak_height;
    assign last             = out_res.last;

    // Every accepted item produces a beat from the core in the next cycle.
    a_item_yields_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> core_valid)
        else $error("accepted item produced no result beat");

    // No new item while the core still owes beats for the current one.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        core_valid |-> !in_ready)
        else $error("input accepted while results were pending");

    // The shared and local regions both lie below the top.
    a_regions_fit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (({1'b0, local_depth} + {1'b0, shared_available})
                       <= {1'b0, top_position}))
        else $error("stack regions exceed top index");

    // A granted request never carries an error code.
    a_success_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && success |-> error_code == ERR_NONE)
        else $error("success with error code");

endmodule

// ===== bench/swss_tb_pkg.sv =====
`timescale 1ns / 1ps

package swss_tb_pkg;

    import swss_pkg::*;

    localparam logic [TASK_W-1:0] HANDLE_MASK = {TASK_W{1'b1}} >> (TASK_W - HANDLE_WIDTH);

    // Shadow copy of the split stack. It predicts the result beats of each
    // accepted request and matches them against what the block returns.
    class stack_shadow;

        logic [TASK_W-1:0]   entries [STACK_DEPTH];
        logic [IDX_W-1:0]    top_idx;
        logic [IDX_W-1:0]    boundary;
        logic [IDX_W-1:0]    steal_base;
        logic [IDX_W-1:0]    deepest;
        logic [IDX_W-1:0]    capacity;
        logic [COUNT_W-1:0]  pushes;
        logic [HEIGHT_W-1:0] tallest;
        res_t                beats_due[$];
        int unsigned         bad_beats;

        function new();
            top_idx    = '0;
            boundary   = '0;
            steal_base = '0;
            deepest    = '0;
            pushes     = '0;
            tallest    = '0;
            capacity   = IDX_W'(STACK_DEPTH);
            bad_beats  = 0;
        endfunction

        function void set_capacity(logic [IDX_W-1:0] value);
            capacity = value;
        endfunction

        // Every beat reports the indices and counters as they stand after
        // the request has taken effect.
        function void queue_beat(logic [TASK_W-1:0] task_val, logic ok,
                                 logic [ERR_W-1:0] err, logic fin);
            res_t beat;
            beat.task_out         = task_val & HANDLE_MASK;
            beat.success          = ok;
            beat.error_code       = err;
            beat.local_depth      = top_idx - boundary;
            beat.shared_available = boundary - steal_base;
            beat.top_position     = top_idx;
            beat.pushed_total     = pushes;
            beat.peak_depth       = deepest;
            beat.peak_height      = tallest;
            beat.last             = fin;
            beats_due.push_back(beat);
        endfunction

        function void take_request(logic [KIND_W-1:0] op, logic [TASK_W-1:0] handle,
                                   logic [HEIGHT_W-1:0] height, logic [AMT_W-1:0] amt);
            logic [IDX_W-1:0] limit;
            logic [IDX_W-1:0] first;
            int               i;
            limit = (capacity < STACK_DEPTH) ? capacity : IDX_W'(STACK_DEPTH);
            case (op)
                KIND_PUSH:
                begin
                    if (top_idx >= limit)
                    begin
                        queue_beat('0, 1'b0, ERR_OVERFLOW, 1'b1);
                    end
                    else
                    begin
                        entries[top_idx] = handle & HANDLE_MASK;
                        top_idx = top_idx + 1'b1;
                        pushes = pushes + 1'b1;
                        if (top_idx > deepest)
                        begin
                            deepest = top_idx;
                        end
                        if (height > tallest)
                        begin
                            tallest = height;
                        end
                        queue_beat('0, 1'b1, ERR_NONE, 1'b1);
                    end
                end
                KIND_POP:
                begin
                    if (top_idx <= boundary)
                    begin
                        queue_beat('0, 1'b0, ERR_EMPTY, 1'b1);
                    end
                    else
                    begin
                        top_idx = top_idx - 1'b1;
                        queue_beat(entries[top_idx], 1'b1, ERR_NONE, 1'b1);
                    end
                end
                KIND_RELEASE:
                begin
                    if (top_idx - boundary >= amt)
                    begin
                        boundary = boundary + amt;
                        queue_beat('0, 1'b1, ERR_NONE, 1'b1);
                    end
                    else
                    begin
                        queue_beat('0, 1'b0, ERR_RELEASE, 1'b1);
                    end
                end
                KIND_ACQUIRE:
                begin
                    if (boundary - steal_base >= amt)
                    begin
                        boundary = boundary - amt;
                        queue_beat('0, 1'b1, ERR_NONE, 1'b1);
                    end
                    else
                    begin
                        queue_beat('0, 1'b0, ERR_NONE, 1'b1);
                    end
                end
                KIND_STEAL:
                begin
                    if (amt > MAX_CHUNK || boundary - steal_base < amt)
                    begin
                        queue_beat('0, 1'b0, ERR_NONE, 1'b1);
                    end
                    else
                    begin
                        first = steal_base;
                        steal_base = steal_base + amt;
                        if (amt == 0)
                        begin
                            queue_beat('0, 1'b1, ERR_NONE, 1'b1);
                        end
                        else
                        begin
                            for (i = 0; i < amt; i++)
                            begin
                                queue_beat(entries[first + i], 1'b1, ERR_NONE, i == amt - 1);
                            end
                        end
                    end
                end
                KIND_EMPTY:
                begin
                    top_idx    = '0;
                    boundary   = '0;
                    steal_base = '0;
                    deepest    = '0;
                    queue_beat('0, 1'b1, ERR_NONE, 1'b1);
                end
                default:
                begin
                    queue_beat('0, 1'b0, ERR_NONE, 1'b1);
                end
            endcase
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                bad_beats++;
            end
        endfunction

        function void match_beat(res_t got);
            res_t want;
            if (beats_due.size() == 0)
            begin
                $error("result beat with nothing outstanding: task_out %0h", got.task_out);
                bad_beats++;
                return;
            end
            want = beats_due.pop_front();
            compare_field("task_out", want.task_out, got.task_out);
            compare_field("success", want.success, got.success);
            compare_field("error_code", want.error_code, got.error_code);
            compare_field("local_depth", want.local_depth, got.local_depth);
            compare_field("shared_available", want.shared_available, got.shared_available);
            compare_field("top_position", want.top_position, got.top_position);
            compare_field("pushed_total", want.pushed_total, got.pushed_total);
            compare_field("peak_depth", want.peak_depth, got.peak_depth);
            compare_field("peak_height", want.peak_height, got.peak_height);
            compare_field("last", want.last, got.last);
        endfunction

    endclass

endpackage

// ===== bench/split_work_stealing_stack_unit_tb.sv =====
`timescale 1ns / 1ps

module split_work_stealing_stack_unit_tb;

    import swss_pkg::*;
    import swss_tb_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 48;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [KIND_W-1:0]   kind = KIND_PUSH;
    logic [TASK_W-1:0]   task_handle = '0;
    logic [HEIGHT_W-1:0] task_height = '0;
    logic [AMT_W-1:0]    amount = '0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [TASK_W-1:0]   task_out;
    logic                success;
    logic [ERR_W-1:0]    error_code;
    logic [IDX_W-1:0]    local_depth;
    logic [IDX_W-1:0]    shared_available;
    logic [IDX_W-1:0]    top_position;
    logic [COUNT_W-1:0]  pushed_total;
    logic [IDX_W-1:0]    peak_depth;
    logic [HEIGHT_W-1:0] peak_height;
    logic                last;

    stack_shadow shadow;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned random_count   = 0;

    split_work_stealing_stack_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .kind             (kind),
        .task_handle      (task_handle),
        .task_height      (task_height),
        .amount           (amount),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .task_out         (task_out),
        .success          (success),
        .error_code       (error_code),
        .local_depth      (local_depth),
        .shared_available (shared_available),
        .top_position     (top_position),
        .pushed_total     (pushed_total),
        .peak_depth       (peak_depth),
        .peak_height      (peak_height),
        .last             (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            shadow.match_beat({task_out, success, error_code, local_depth, shared_available,
                               top_position, pushed_total, peak_depth, peak_height, last});
        end
    end

    // Presents one request and holds it until the block takes the beat.
    task automatic send_item(logic [KIND_W-1:0] op, logic [TASK_W-1:0] handle,
                             logic [HEIGHT_W-1:0] height, logic [AMT_W-1:0] amt);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= op;
        task_handle <= handle;
        task_height <= height;
        amount      <= amt;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        shadow.take_request(op, handle, height, amt);
    endtask

    task automatic wait_drained();
        while (shadow.beats_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_capacity(logic [IDX_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        shadow.set_capacity(value);
        cfg_valid <= 1'b0;
    endtask

    // Mostly requests that fit the current regions, so that the stack fills
    // and steals reach full chunks; the rest are arbitrary.
    task automatic send_random();
        logic [KIND_W-1:0]   op;
        logic [AMT_W-1:0]    amt;
        logic [HEIGHT_W-1:0] height;
        int unsigned         roll;
        int unsigned         local_n;
        int unsigned         shared_n;
        local_n  = shadow.top_idx - shadow.boundary;
        shared_n = shadow.boundary - shadow.steal_base;
        roll = $urandom_range(0, 99);
        if (roll < 38)
            op = KIND_PUSH;
        else if (roll < 52)
            op = KIND_POP;
        else if (roll < 66)
            op = KIND_RELEASE;
        else if (roll < 76)
            op = KIND_ACQUIRE;
        else if (roll < 94)
            op = KIND_STEAL;
        else if (roll < 97)
            op = KIND_EMPTY;
        else
            op = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
        amt = AMT_W'($urandom_range(0, 31));
        if ($urandom_range(0, 9) < 8)
        begin
            if (op == KIND_RELEASE)
                amt = AMT_W'($urandom_range(0, (local_n < 31) ? local_n : 31));
            else if (op == KIND_ACQUIRE)
                amt = AMT_W'($urandom_range(0, (shared_n < 31) ? shared_n : 31));
            else if (op == KIND_STEAL && shared_n > 16 && $urandom_range(0, 4) == 0)
                amt = AMT_W'($urandom_range(17, (shared_n < 31) ? shared_n : 31));
            else if (op == KIND_STEAL && shared_n > 0)
                amt = AMT_W'($urandom_range(1, (shared_n < MAX_CHUNK) ? shared_n : MAX_CHUNK));
        end
        // Heights climb slowly so that the peak keeps moving during the run.
        if ($urandom_range(0, 99) == 0)
            height = '1;
        else
            height = HEIGHT_W'($urandom_range(0, 200 * (random_count + 1)));
        random_count++;
        send_item(op, {$urandom, $urandom}, height, amt);
    endtask

    initial
    begin
        logic [IDX_W-1:0] caps [RANDOM_PHASES];
        int p;
        int n;
        caps = '{IDX_W'(1024), IDX_W'(20), IDX_W'(1), IDX_W'(0), IDX_W'(2047), IDX_W'(1024)};
        shadow = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every kind but EMPTY against an empty stack first.
        send_item(KIND_POP, '0, '0, 5'd0);
        send_item(KIND_RELEASE, '0, '0, 5'd31);
        send_item(KIND_RELEASE, '0, '0, 5'd0);
        send_item(KIND_ACQUIRE, '0, '0, 5'd1);
        send_item(KIND_ACQUIRE, '0, '0, 5'd0);
        send_item(KIND_STEAL, '0, '0, 5'd0);
        send_item(KIND_STEAL, '0, '0, 5'd1);
        send_item(KIND_SPARE_LO, '1, '1, 5'd31);
        send_item(KIND_SPARE_HI, '0, '0, 5'd16);
        send_item(KIND_PUSH, '1, '0, 5'd0);
        send_item(KIND_PUSH, '0, 16'd1, 5'd31);
        for (n = 0; n < 6; n++)
        begin
            send_item(KIND_PUSH, {$urandom, $urandom}, HEIGHT_W'($urandom_range(2, 300)), '0);
        end
        // Share everything, then the owner has nothing local to pop.
        send_item(KIND_RELEASE, '0, '0, 5'd8);
        send_item(KIND_POP, '0, '0, 5'd0);
        send_item(KIND_STEAL, '0, '0, 5'd17);
        send_item(KIND_STEAL, '0, '0, 5'd3);
        send_item(KIND_ACQUIRE, '0, '0, 5'd5);
        send_item(KIND_POP, '0, '0, 5'd0);
        send_item(KIND_RELEASE, '0, '0, 5'd31);
        send_item(KIND_EMPTY, '0, '0, 5'd0);
        in_valid <= 1'b0;
        wait_drained();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            write_capacity(caps[p]);
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 51;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 51;
                end
                default:
                begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 7;
                end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_random();
            end
            in_valid <= 1'b0;
            wait_drained();
        end

        repeat (16) @(posedge clk);
        if (shadow.bad_beats == 0 && shadow.beats_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
